// ===== sv/amou_pkg.sv =====
`default_nettype none

package amou_pkg;

    localparam int unsigned FUNC_W    = 4;
    localparam int unsigned ADDR_W    = 12;
    localparam int unsigned SIZE_W    = 2;
    localparam int unsigned DATA_W    = 32;
    // word index taken from a byte address
    localparam int unsigned WADDR_W   = ADDR_W - 2;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_func FN_ADD     = 4'd0;
    localparam t_func FN_SUB     = 4'd1;
    localparam t_func FN_OR      = 4'd2;
    localparam t_func FN_AND     = 4'd3;
    localparam t_func FN_XOR     = 4'd4;
    localparam t_func FN_NAND    = 4'd5;
    localparam t_func FN_CAS     = 4'd6;
    localparam t_func FN_SWAP    = 4'd7;
    localparam t_func FN_RELEASE = 4'd8;

    localparam t_size SZ_BYTE = 2'd0;
    localparam t_size SZ_HALF = 2'd1;

    localparam t_data       LANE_MASK_BYTE     = 32'h0000_00ff;
    localparam t_data       LANE_MASK_HALF     = 32'h0000_ffff;
    localparam logic [4:0]  BE_FLIP_BYTE       = 5'd24;
    localparam logic [4:0]  BE_FLIP_HALF       = 5'd16;
    localparam int unsigned ADDR_SHIFT_TO_BITS = 3;

    typedef struct packed {
        logic clr_we;    // write zero at the clear counter
        logic accept;    // capture request, read memory when index is direct
        logic index_rd;  // read memory at the reduced index
        logic exec;      // modify, write back, load result
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic idx_direct;
        logic out_free;
    } t_dp_status;

    function automatic t_data apply_op(input t_func func, input t_data old_v,
                                       input t_data val);
        t_data res;
        case (func)
            FN_ADD:  res = old_v + val;
            FN_SUB:  res = old_v - val;
            FN_OR:   res = old_v | val;
            FN_AND:  res = old_v & val;
            FN_XOR:  res = old_v ^ val;
            default: res = ~(old_v & val);
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/amou_if.sv =====
`default_nettype none

interface amou_req_if;
    logic                          valid;
    logic                          ready;
    amou_pkg::t_func               func;
    logic [amou_pkg::ADDR_W-1:0]   byte_address;
    amou_pkg::t_size               access_size;
    logic                          return_new;
    amou_pkg::t_data               operand;
    amou_pkg::t_data               compare_value;

    modport source (output valid, func, byte_address, access_size, return_new,
                    operand, compare_value, input ready);
    modport sink   (input valid, func, byte_address, access_size, return_new,
                    operand, compare_value, output ready);
endinterface

interface amou_rsp_if;
    logic            valid;
    logic            ready;
    amou_pkg::t_data result_value;
    logic            cas_success;

    modport source (output valid, result_value, cas_success, input ready);
    modport sink   (input valid, result_value, cas_success, output ready);
endinterface

`default_nettype wire

// ===== sv/amou_ctrl.sv =====
`default_nettype none

module amou_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire amou_pkg::t_dp_status i_status,
    output amou_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.idx_direct ? S_EXEC : S_INDEX;
                end
            end
            S_INDEX: begin
                o_cmd.index_rd = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                // wait for room in the result register
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_we, o_cmd.accept, o_cmd.index_rd, o_cmd.exec}))
        else $error("more than one datapath command at once");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC || r_state == S_INDEX))
        else $error("accepted request not followed by index or execute");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_status.clr_last) |=> r_state == S_IDLE)
        else $error("clearing pass did not end at last word");

endmodule

`default_nettype wire

// ===== sv/amou_dp.sv =====
`default_nettype none

module amou_dp #(
    parameter int unsigned MEM_WORDS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire amou_pkg::t_ctrl_cmd           i_cmd,
    output amou_pkg::t_dp_status               o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire amou_pkg::t_func               i_func,
    input  wire logic [amou_pkg::ADDR_W-1:0]   i_byte_address,
    input  wire amou_pkg::t_size               i_access_size,
    input  wire logic                          i_return_new,
    input  wire amou_pkg::t_data               i_operand,
    input  wire amou_pkg::t_data               i_compare_value,
    amou_rsp_if.source                         o_rsp
);

    localparam int unsigned IDX_W   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam bit          POW2    = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam bit          DIRECT  = POW2 || (MEM_WORDS >= (1 << amou_pkg::WADDR_W));
    localparam int unsigned RECIP_K = 2 * amou_pkg::WADDR_W;
    localparam int unsigned PROD_W  = RECIP_K + amou_pkg::WADDR_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_K) + MEM_WORDS - 1) / MEM_WORDS;

    logic [amou_pkg::WADDR_W-1:0] in_waddr;
    logic [IDX_W-1:0]             idx_in;
    logic [IDX_W-1:0]             idx_calc;
    logic [IDX_W-1:0]             rd_addr;
    logic [IDX_W-1:0]             wr_addr;
    logic                         rd_en;
    logic                         wr_en;
    amou_pkg::t_data              wr_data;

    logic                         r_big_endian;
    amou_pkg::t_func              r_func;
    logic [1:0]                   r_lane_addr;
    amou_pkg::t_size              r_size;
    logic                         r_ret_new;
    amou_pkg::t_data              r_operand;
    amou_pkg::t_data              r_cmpv;
    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             r_clr_cnt;
    amou_pkg::t_data              r_rd_word;
    amou_pkg::t_data              r_mem [MEM_WORDS];

    logic                         r_out_valid;
    amou_pkg::t_data              r_result;
    logic                         r_cas_success;

    // lane decode and update
    logic [4:0]                   shift;
    amou_pkg::t_data              lmask;
    amou_pkg::t_data              mask;
    amou_pkg::t_data              old_lane;
    amou_pkg::t_data              new_lane;
    amou_pkg::t_data              n_result;
    logic                         n_cas;
    logic                         do_write;
    amou_pkg::t_data              new_word;

    assign in_waddr = i_byte_address[amou_pkg::ADDR_W-1:2];

    generate
        if (DIRECT) begin : g_direct
            if (POW2) begin : g_mask
                assign idx_in = IDX_W'(32'(in_waddr) & (MEM_WORDS - 1));
            end else begin : g_fit
                assign idx_in = IDX_W'(in_waddr);
            end
            assign idx_calc = r_idx;
        end else begin : g_reduce
            // word index mod MEM_WORDS: reciprocal multiply gives the exact
            // quotient for a 10-bit index, constant multiply then subtract
            localparam logic [amou_pkg::WADDR_W-1:0] M_L =
                amou_pkg::WADDR_W'(MEM_WORDS);
            logic [amou_pkg::WADDR_W-1:0]   r_waddr;
            logic [amou_pkg::WADDR_W-1:0]   r_quot;
            logic [PROD_W-1:0]              prod;
            logic [RECIP_K-1:0]             qm;

            assign prod   = PROD_W'(in_waddr) * PROD_W'(RECIP);
            assign qm     = RECIP_K'(r_quot) * RECIP_K'(M_L);
            assign idx_in = '0;
            assign idx_calc =
                IDX_W'(r_waddr - qm[amou_pkg::WADDR_W-1:0]);

            always_ff @(posedge i_clk) begin
                if (i_cmd.accept) begin
                    r_waddr <= in_waddr;
                    r_quot  <= prod[RECIP_K +: amou_pkg::WADDR_W];
                end
            end
        end
    endgenerate

    assign rd_en   = (i_cmd.accept && DIRECT) || i_cmd.index_rd;
    assign rd_addr = i_cmd.index_rd ? idx_calc : idx_in;

    always_comb begin
        shift = '0;
        lmask = '1;
        case (r_size)
            amou_pkg::SZ_BYTE: begin
                shift = 5'({r_lane_addr, 3'b000});
                if (r_big_endian) begin
                    shift = shift ^ amou_pkg::BE_FLIP_BYTE;
                end
                lmask = amou_pkg::LANE_MASK_BYTE;
            end
            amou_pkg::SZ_HALF: begin
                shift = 5'({3'b000, r_lane_addr[1], 1'b0} << amou_pkg::ADDR_SHIFT_TO_BITS);
                if (r_big_endian) begin
                    shift = shift ^ amou_pkg::BE_FLIP_HALF;
                end
                lmask = amou_pkg::LANE_MASK_HALF;
            end
            default: begin
                shift = '0;
                lmask = '1;
            end
        endcase
        mask     = lmask << shift;
        old_lane = (r_rd_word & mask) >> shift;
    end

    always_comb begin
        new_lane = '0;
        n_result = old_lane;
        n_cas    = 1'b0;
        do_write = 1'b0;
        case (r_func) inside
            amou_pkg::FN_ADD, amou_pkg::FN_SUB, amou_pkg::FN_OR,
            amou_pkg::FN_AND, amou_pkg::FN_XOR, amou_pkg::FN_NAND: begin
                new_lane = amou_pkg::apply_op(r_func, old_lane, r_operand) & lmask;
                do_write = 1'b1;
                n_result = r_ret_new ? new_lane : old_lane;
            end
            amou_pkg::FN_CAS: begin
                if (old_lane == (r_cmpv & lmask)) begin
                    new_lane = r_operand & lmask;
                    do_write = 1'b1;
                    n_cas    = 1'b1;
                end
            end
            amou_pkg::FN_SWAP: begin
                new_lane = r_operand & lmask;
                do_write = 1'b1;
            end
            amou_pkg::FN_RELEASE: begin
                do_write = 1'b1;
                n_result = '0;
            end
            default: begin
                n_result = old_lane;
            end
        endcase
        new_word = (r_rd_word & ~mask) | ((new_lane << shift) & mask);
    end

    assign wr_en   = i_cmd.clr_we || (i_cmd.exec && do_write);
    assign wr_addr = i_cmd.clr_we ? r_clr_cnt : r_idx;
    assign wr_data = i_cmd.clr_we ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_idx <= rd_addr;
        end
        if (i_cmd.accept) begin
            r_func      <= i_func;
            r_lane_addr <= i_byte_address[1:0];
            r_size      <= i_access_size;
            r_ret_new   <= i_return_new;
            r_operand   <= i_operand;
            r_cmpv      <= i_compare_value;
        end
        if (i_cmd.exec) begin
            r_result      <= n_result;
            r_cas_success <= n_cas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_big_endian <= i_cfg_wdata;
            end
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clr_last   = (r_clr_cnt == IDX_W'(MEM_WORDS - 1));
    assign o_status.idx_direct = DIRECT;
    assign o_status.out_free   = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_result;
    assign o_rsp.cas_success  = r_cas_success;

    a_exec_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("execute did not load result register");

    a_cas_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (!r_cas_success || $past(r_func) == amou_pkg::FN_CAS))
        else $error("success flag set for non compare-and-swap");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_func == amou_pkg::FN_RELEASE) |=> r_result == '0)
        else $error("release returned nonzero value");

endmodule

`default_nettype wire

// ===== sv/atomic_memory_op_unit_core.sv =====
// Timing: on acceptance the request is captured and the memory word read into a register;
//   with index reduction (MEM_WORDS not a power of two and below 1024) an index state reads it.
// Execute then loads the result register, waiting while it is full. Requests do not overlap:
//   the next is taken only after the read-then-write of the word memory for the last one.
// Reset: synchronous, active low; a clearing pass then zeroes the memory,
//   one word a cycle up to the last word, with no request accepted meanwhile.
`default_nettype none

module atomic_memory_op_unit_core #(
    parameter int unsigned MEM_WORDS = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    amou_req_if.sink   i_req,
    amou_rsp_if.source o_rsp
);

    // command/status between controller and datapath
    amou_pkg::t_ctrl_cmd  cmd;
    amou_pkg::t_dp_status status;

    // Controller: clear sweep after reset, then idle -> (index) -> execute.
    // Request beat taken only in idle; result stays in the output register
    // while the next request is taken, execute waits until it drains.
    amou_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: word memory with registered read, lane select by shift and
    // mask (endianness flips the lane offset), ALU and merge back into the
    // word, result register. Config register big_endian lives here and may
    // be written any cycle, including during the clear sweep.
    amou_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_func          (i_req.func),
        .i_byte_address  (i_req.byte_address),
        .i_access_size   (i_req.access_size),
        .i_return_new    (i_req.return_new),
        .i_operand       (i_req.operand),
        .i_compare_value (i_req.compare_value),
        .o_rsp           (o_rsp)
    );

endmodule

`default_nettype wire
